// File: hw/rtl/bcts_pkg.sv
// Shared types and constants of the byte command time switch.
// No dependencies; imported by bcts_core and the top level.
package bcts_pkg;

  localparam int CHANNELS    = 4;   // switch channels, 1..8
  localparam int SWITCH_BITS = 4;   // channels shown on the result

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // command bytes
  localparam logic [7:0] CH_CONNECT = 8'h2A;  // '*'
  localparam logic [7:0] CH_SW0     = 8'h77;  // 'w'
  localparam logic [7:0] CH_SW1     = 8'h78;  // 'x'
  localparam logic [7:0] CH_SW2     = 8'h79;  // 'y'
  localparam logic [7:0] CH_SW3     = 8'h7A;  // 'z'
  localparam logic [7:0] CH_HALL    = 8'h73;  // 's'
  localparam logic [7:0] CH_ROOM    = 8'h68;  // 'h'
  localparam logic [7:0] CH_ON      = 8'h69;  // 'i'
  localparam logic [7:0] CH_OFF     = 8'h66;  // 'f'
  localparam logic [7:0] CH_SELECT  = 8'h6D;  // 'm'

  localparam logic [5:0] HOUR_MASK = 6'h3F;

  typedef struct packed {
    logic       command;   // 0 = byte, 1 = clock tick
    logic [7:0] rx_byte;
    logic [6:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } bcts_item_t;

  typedef struct packed {
    logic [SWITCH_BITS-1:0] switch_states;
    logic [7:0]             hall_level;
    logic [7:0]             room_level;
    logic                   linked;
  } bcts_result_t;

endpackage

// File: hw/rtl/bcts_core.sv
// Command decoder, time stores and tick matcher of the time switch.
// Holds all block state; updates it on upd. Depends on bcts_pkg.
module bcts_core
  import bcts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         upd,
  input  bcts_item_t   item,
  output bcts_result_t result
);

  // floor(255*d/100) == (d * LEVEL_RECIP) >> 19 for every 8-bit d
  localparam logic [20:0] LEVEL_RECIP = 21'd1336965;
  localparam int EN_ON_HOUR  = 0;
  localparam int EN_ON_MIN   = 1;
  localparam int EN_OFF_HOUR = 2;
  localparam int EN_OFF_MIN  = 3;

  function automatic logic [7:0] level_of(input logic [7:0] d);
    logic [28:0] p;
    p = 29'(d) * 29'(LEVEL_RECIP);
    return p[26:19];
  endfunction

  function automatic logic [7:0] bcd_of(input logic [7:0] d);
    logic [15:0] t;
    logic [4:0]  q;
    logic [3:0]  r;
    t = 16'(d) * 16'd205;   // d/10 for d < 1029
    q = t[15:11];
    r = 4'(d - 8'(q) * 8'd10);
    return 8'({q, 4'b0000}) + 8'(r);
  endfunction

  logic                linked, linked_next;
  logic                hall_pend, hall_pend_next;
  logic                room_pend, room_pend_next;
  logic                on_pend, on_pend_next;
  logic                off_pend, off_pend_next;
  logic                sel_pend, sel_pend_next;
  logic                minute_sel, minute_sel_next;
  logic [7:0]          chosen, chosen_next;
  logic [7:0]          on_hour   [CHANNELS], on_hour_next   [CHANNELS];
  logic [7:0]          on_min    [CHANNELS], on_min_next    [CHANNELS];
  logic [7:0]          off_hour  [CHANNELS], off_hour_next  [CHANNELS];
  logic [7:0]          off_min   [CHANNELS], off_min_next   [CHANNELS];
  logic [3:0]          enable    [CHANNELS], enable_next    [CHANNELS];
  logic [CHANNELS-1:0] sw, sw_next;
  logic [7:0]          hall, hall_next;
  logic [7:0]          room, room_next;

  logic [7:0] d;
  logic [7:0] bcd;
  logic       nz;
  logic       ch_ok;
  logic       m0, m1;
  logic [7:0] hour_cmp;
  logic [7:0] min_cmp;
  logic       sec_zero;
  logic [CHANNELS+SWITCH_BITS-1:0] sw_wide;

  assign d        = item.rx_byte;
  assign bcd      = bcd_of(d);
  assign nz       = (d != 8'd0);
  assign ch_ok    = (chosen != 8'd0) && (chosen <= 8'(CHANNELS));
  assign hour_cmp = {2'b00, item.hour_bcd[5:0] & HOUR_MASK};
  assign min_cmp  = {1'b0, item.minute_bcd};
  assign sec_zero = (item.second_bcd == 7'd0);

  always_comb begin
    linked_next     = linked;
    hall_pend_next  = hall_pend;
    room_pend_next  = room_pend;
    on_pend_next    = on_pend;
    off_pend_next   = off_pend;
    sel_pend_next   = sel_pend;
    minute_sel_next = minute_sel;
    chosen_next     = chosen;
    on_hour_next    = on_hour;
    on_min_next     = on_min;
    off_hour_next   = off_hour;
    off_min_next    = off_min;
    enable_next     = enable;
    sw_next         = sw;
    hall_next       = hall;
    room_next       = room;
    m0              = minute_sel;
    m1              = minute_sel;

    if (!item.command) begin
      if (!linked) begin
        if (d == CH_CONNECT) linked_next = 1'b1;
      end else begin
        case (d)
          CH_SW0, CH_SW1, CH_SW2, CH_SW3: begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (d == 8'(CH_SW0 + 8'(c))) sw_next[c] = ~sw[c];
            end
          end
          CH_HALL:   hall_pend_next = 1'b1;
          CH_ROOM:   room_pend_next = 1'b1;
          CH_ON:     on_pend_next   = 1'b1;
          CH_OFF:    off_pend_next  = 1'b1;
          CH_SELECT: sel_pend_next  = 1'b1;
          default: begin
            if (hall_pend) begin
              hall_next      = level_of(d);
              hall_pend_next = 1'b0;
            end
            if (room_pend) begin
              room_next      = level_of(d);
              room_pend_next = 1'b0;
            end
            // on and off share the hour/minute phase; on goes first
            if (on_pend) begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (ch_ok && chosen == 8'(c + 1)) begin
                  if (m0) begin
                    on_min_next[c]            = bcd;
                    enable_next[c][EN_ON_MIN] = nz;
                  end else begin
                    on_hour_next[c]            = bcd;
                    enable_next[c][EN_ON_HOUR] = nz;
                  end
                end
              end
              if (m0) on_pend_next = 1'b0;
              m1 = ~m0;
            end
            if (off_pend) begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (ch_ok && chosen == 8'(c + 1)) begin
                  if (m1) begin
                    off_min_next[c]            = bcd;
                    enable_next[c][EN_OFF_MIN] = nz;
                  end else begin
                    off_hour_next[c]            = bcd;
                    enable_next[c][EN_OFF_HOUR] = nz;
                  end
                end
              end
              if (m1) off_pend_next = 1'b0;
              minute_sel_next = ~m1;
            end else begin
              minute_sel_next = m1;
            end
            if (sel_pend) begin
              chosen_next   = d;
              sel_pend_next = 1'b0;
            end
          end
        endcase
      end
    end else begin
      // clock tick: on match sets, a later off match on the same tick wins
      for (int c = 0; c < CHANNELS; c++) begin
        if ((enable[c][1:0] != 2'b00) && on_hour[c] == hour_cmp &&
            on_min[c] == min_cmp && sec_zero)
          sw_next[c] = 1'b1;
        if ((enable[c][3:2] != 2'b00) && off_hour[c] == hour_cmp &&
            off_min[c] == min_cmp && sec_zero)
          sw_next[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      linked     <= 1'b0;
      hall_pend  <= 1'b0;
      room_pend  <= 1'b0;
      on_pend    <= 1'b0;
      off_pend   <= 1'b0;
      sel_pend   <= 1'b0;
      minute_sel <= 1'b0;
      chosen     <= 8'd0;
      for (int c = 0; c < CHANNELS; c++) begin
        on_hour[c]  <= 8'd0;
        on_min[c]   <= 8'd0;
        off_hour[c] <= 8'd0;
        off_min[c]  <= 8'd0;
        enable[c]   <= 4'd0;
      end
      sw   <= '0;
      hall <= 8'd0;
      room <= 8'd0;
    end else if (upd) begin
      linked     <= linked_next;
      hall_pend  <= hall_pend_next;
      room_pend  <= room_pend_next;
      on_pend    <= on_pend_next;
      off_pend   <= off_pend_next;
      sel_pend   <= sel_pend_next;
      minute_sel <= minute_sel_next;
      chosen     <= chosen_next;
      on_hour    <= on_hour_next;
      on_min     <= on_min_next;
      off_hour   <= off_hour_next;
      off_min    <= off_min_next;
      enable     <= enable_next;
      sw         <= sw_next;
      hall       <= hall_next;
      room       <= room_next;
    end
  end

  // result reflects the state after this request
  assign sw_wide              = {{SWITCH_BITS{1'b0}}, sw_next};
  assign result.switch_states = sw_wide[SWITCH_BITS-1:0];
  assign result.hall_level    = hall_next;
  assign result.room_level    = room_next;
  assign result.linked        = linked_next;

endmodule

// File: hw/rtl/byte_command_time_switch_unit.sv
// Top level of the byte command time switch: stream ports, input and
// result registers around bcts_core. Depends on bcts_pkg and bcts_core.
// Requests pass the input register, then the result register, one request
// per cycle unless m_axis stalls; the input register feeds the core, which
// updates its state and loads the result register in the same cycle.
// Reset (rst, synchronous): both stages empty, all state and levels zero.
module byte_command_time_switch_unit
  import bcts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] rx_byte, [14:8] hour_bcd, [21:15] minute_bcd, [28:22] second_bcd
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] command
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [3:0] switch_states, [11:4] hall_level, [19:12] room_level, [20] linked
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic         in_valid;
  bcts_item_t   in_item;
  logic         out_valid;
  bcts_result_t out_res;
  bcts_result_t core_res;
  logic         advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.command    <= s_axis_tuser;
      in_item.rx_byte    <= s_axis_tdata[7:0];
      in_item.hour_bcd   <= s_axis_tdata[14:8];
      in_item.minute_bcd <= s_axis_tdata[21:15];
      in_item.second_bcd <= s_axis_tdata[28:22];
    end
    if (advance) out_res <= core_res;
  end

  bcts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .upd    (advance),
    .item   (in_item),
    .result (core_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.linked, out_res.room_level,
                          out_res.hall_level, out_res.switch_states};

endmodule

// File: verif/bcts_result_monitor.sv
// Result monitor for byte_command_time_switch_unit: watches both stream channels,
// predicts each result from the accepted requests and compares field by field.
// Depends on bcts_pkg only.
module bcts_result_monitor
  import bcts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // [7:0] rx_byte, [14:8] hour_bcd, [21:15] minute_bcd, [28:22] second_bcd
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] command
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [3:0] switch_states, [11:4] hall_level, [19:12] room_level, [20] linked
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   errors,
  output int                   waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted block state
  logic                linked_q;
  logic                hall_armed, room_armed, on_armed, off_armed, select_armed;
  logic                minute_phase;
  logic [7:0]          channel_sel;
  logic [7:0]          on_hour[CHANNELS];
  logic [7:0]          on_minute[CHANNELS];
  logic [7:0]          off_hour[CHANNELS];
  logic [7:0]          off_minute[CHANNELS];
  logic [3:0]          enables[CHANNELS];
  logic [CHANNELS-1:0] switch_bits;
  logic [7:0]          hall_q, room_q;

  bcts_result_t expected_results[$];

  function automatic logic [7:0] dimmer_level(input logic [7:0] d);
    int unsigned v;
    v = (255 * int'(d)) / 100;
    return v[7:0];
  endfunction

  function automatic logic [7:0] to_bcd(input logic [7:0] d);
    int unsigned v;
    v = ((int'(d) / 10) << 4) + (int'(d) % 10);
    return v[7:0];
  endfunction

  function void clear_model();
    linked_q     = 1'b0;
    hall_armed   = 1'b0;
    room_armed   = 1'b0;
    on_armed     = 1'b0;
    off_armed    = 1'b0;
    select_armed = 1'b0;
    minute_phase = 1'b0;
    channel_sel  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      on_hour[c]    = '0;
      on_minute[c]  = '0;
      off_hour[c]   = '0;
      off_minute[c] = '0;
      enables[c]    = '0;
    end
    switch_bits = '0;
    hall_q      = '0;
    room_q      = '0;
  endfunction

  // One time byte: hour first, then minute; out-of-range channel stores nothing
  function void store_time(input logic [7:0] d, input logic is_off);
    logic [7:0] b;
    int         ch;
    int         bit_idx;
    b       = to_bcd(d);
    ch      = int'(channel_sel) - 1;
    bit_idx = (is_off ? 2 : 0) + (minute_phase ? 1 : 0);
    if (channel_sel >= 1 && int'(channel_sel) <= CHANNELS) begin
      if (minute_phase) begin
        if (is_off) off_minute[ch] = b;
        else on_minute[ch] = b;
      end else begin
        if (is_off) off_hour[ch] = b;
        else on_hour[ch] = b;
      end
      enables[ch][bit_idx] = (d != 8'd0);
    end
    if (minute_phase) begin
      if (is_off) off_armed = 1'b0;
      else on_armed = 1'b0;
      minute_phase = 1'b0;
    end else begin
      minute_phase = 1'b1;
    end
  endfunction

  function void apply_byte(input logic [7:0] d);
    int idx;
    if (!linked_q) begin
      if (d == CH_CONNECT) linked_q = 1'b1;
      return;
    end
    case (d)
      CH_SW0, CH_SW1, CH_SW2, CH_SW3: begin
        idx = int'(d - CH_SW0);
        if (idx < CHANNELS) switch_bits[idx] = ~switch_bits[idx];
      end
      CH_HALL:   hall_armed = 1'b1;
      CH_ROOM:   room_armed = 1'b1;
      CH_ON:     on_armed = 1'b1;
      CH_OFF:    off_armed = 1'b1;
      CH_SELECT: select_armed = 1'b1;
      default: begin
        if (hall_armed) begin
          hall_q     = dimmer_level(d);
          hall_armed = 1'b0;
        end
        if (room_armed) begin
          room_q     = dimmer_level(d);
          room_armed = 1'b0;
        end
        if (on_armed) store_time(d, 1'b0);
        if (off_armed) store_time(d, 1'b1);
        if (select_armed) begin
          channel_sel  = d;
          select_armed = 1'b0;
        end
      end
    endcase
  endfunction

  function void apply_tick(input logic [6:0] hr, input logic [6:0] mn, input logic [6:0] sc);
    logic [7:0] h;
    h = {2'b00, hr[5:0] & HOUR_MASK};
    for (int c = 0; c < CHANNELS; c++) begin
      if (enables[c][1:0] != 2'b00 && on_hour[c] == h && on_minute[c] == {1'b0, mn} &&
          sc == 7'd0)
        switch_bits[c] = 1'b1;
      if (enables[c][3:2] != 2'b00 && off_hour[c] == h && off_minute[c] == {1'b0, mn} &&
          sc == 7'd0)
        switch_bits[c] = 1'b0;
    end
  endfunction

  function automatic bcts_result_t current_outputs();
    bcts_result_t r;
    r.switch_states = switch_bits[SWITCH_BITS-1:0];
    r.hall_level    = hall_q;
    r.room_level    = room_q;
    r.linked        = linked_q;
    return r;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bcts_result_t got;
    bcts_result_t want;
    if (rst) begin
      clear_model();
      expected_results.delete();
      errors = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser)
          apply_tick(s_axis_tdata[14:8], s_axis_tdata[21:15], s_axis_tdata[28:22]);
        else
          apply_byte(s_axis_tdata[7:0]);
        expected_results.push_back(current_outputs());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.switch_states = m_axis_tdata[SWITCH_BITS-1:0];
        got.hall_level    = m_axis_tdata[11:4];
        got.room_level    = m_axis_tdata[19:12];
        got.linked        = m_axis_tdata[20];
        if (expected_results.size() == 0) begin
          report("unrequested result", m_axis_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.switch_states != want.switch_states)
            report("switch_states", got.switch_states, want.switch_states);
          if (got.hall_level != want.hall_level)
            report("hall_level", got.hall_level, want.hall_level);
          if (got.room_level != want.room_level)
            report("room_level", got.room_level, want.room_level);
          if (got.linked != want.linked)
            report("linked", got.linked, want.linked);
        end
      end
    end
    waiting = expected_results.size();
  end

endmodule

// File: verif/tb_top.sv
// Top of the byte_command_time_switch_unit testbench: clock, reset, request and
// result traffic, watchdog and verdict. Depends on bcts_pkg, the unit and
// bcts_result_monitor.
module tb_top
  import bcts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS   = 900;
  localparam int unsigned DRAIN_EVERY    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int          errors;
  int          waiting;
  int unsigned taken = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_command_time_switch_unit uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bcts_result_monitor result_mon (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .waiting      (waiting)
  );

  // request count for the sender, and the no-progress watchdog
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) taken <= taken + 1;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: runs of always-ready, mostly-ready, coin-flip stalls and long stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 30);
    end
    stall_left--;
    case (stall_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = 1'($urandom_range(0, 1));
      2:       m_axis_tready = ($urandom_range(0, 3) != 0);
      default: m_axis_tready = (stall_left % 6 == 0);
    endcase
  end

  task automatic send_item(input bcts_item_t it);
    int unsigned mark;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
    end
    s_axis_tuser  = it.command;
    s_axis_tdata  = {3'b000, it.second_bcd, it.minute_bcd, it.hour_bcd, it.rx_byte};
    s_axis_tvalid = 1'b1;
    mark = taken;
    wait (taken != mark);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    bcts_item_t it;
    it.command    = 1'b0;
    it.rx_byte    = b;
    it.hour_bcd   = 7'($urandom_range(0, 127));
    it.minute_bcd = 7'($urandom_range(0, 127));
    it.second_bcd = 7'($urandom_range(0, 127));
    send_item(it);
  endtask

  task automatic send_tick(input logic [6:0] hr, input logic [6:0] mn, input logic [6:0] sc);
    bcts_item_t it;
    it.command    = 1'b1;
    it.rx_byte    = 8'($urandom_range(0, 255));
    it.hour_bcd   = hr;
    it.minute_bcd = mn;
    it.second_bcd = sc;
    send_item(it);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    wait (waiting == 0);
    @(negedge clk);
  endtask

  // small time values so that programmed times and clock ticks meet often
  function automatic logic [7:0] time_digit();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] command_at(input int unsigned k);
    case (k)
      0:       return CH_SW0;
      1:       return CH_SW1;
      2:       return CH_SW2;
      3:       return CH_SW3;
      4:       return CH_HALL;
      5:       return CH_ROOM;
      6:       return CH_ON;
      7:       return CH_OFF;
      8:       return CH_SELECT;
      default: return CH_CONNECT;
    endcase
  endfunction

  initial begin
    int unsigned next_drain;
    int unsigned pick;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: ignored bytes and a tick before connect
    send_byte(CH_SW0);
    send_byte(8'hFF);
    send_tick(7'd0, 7'd0, 7'd0);
    send_byte(CH_CONNECT);
    send_byte(CH_CONNECT);          // now just a data byte
    send_byte(CH_SW0);
    send_byte(CH_SW1);
    send_byte(CH_SW2);
    send_byte(CH_SW3);
    send_byte(CH_HALL);
    send_byte(8'hFF);               // level wraps past 8 bits
    send_byte(CH_ROOM);
    send_byte(8'd100);
    // channel 0 is out of range: times only advance the hour/minute phase
    send_byte(CH_SELECT);
    send_byte(8'd0);
    send_byte(CH_ON);
    send_byte(8'd9);
    send_byte(CH_SELECT);
    send_byte(8'd1);
    send_byte(CH_ON);
    send_byte(8'd12);
    send_byte(8'd30);
    // on and off armed together share the phase bit
    send_byte(CH_OFF);
    send_byte(CH_ON);
    send_byte(8'd5);
    send_byte(8'd6);
    send_byte(8'd0);
    send_tick(7'h46, 7'd0, 7'd0);   // mode bit set, masked hour matches
    send_tick(7'h06, 7'd0, 7'd1);   // nonzero seconds, no match

    drain();
    next_drain = sent + DRAIN_EVERY;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_drain) begin
        drain();
        next_drain = sent + DRAIN_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // program a channel's on and/or off time
        send_byte(CH_SELECT);
        send_byte(($urandom_range(0, 7) != 0) ? 8'($urandom_range(1, CHANNELS))
                                              : 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
          0: send_byte(CH_ON);
          1: send_byte(CH_OFF);
          default: begin
            send_byte(CH_ON);
            send_byte(CH_OFF);
          end
        endcase
        send_byte(time_digit());
        send_byte(time_digit());
      end else if (pick < 55) begin
        if ($urandom_range(0, 2) != 1) send_byte(CH_HALL);
        if ($urandom_range(0, 2) != 0) send_byte(CH_ROOM);
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
        send_byte(command_at($urandom_range(0, 3)));
      end else if (pick < 90) begin
        send_tick({1'($urandom_range(0, 1)), 6'($urandom_range(0, 3))},
                  7'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) != 0) ? 7'd0 : 7'($urandom_range(0, 127)));
      end else if (pick < 95) begin
        send_tick(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
      end else if (pick < 98) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(command_at($urandom_range(0, 9)));
      end
    end

    s_axis_tvalid = 1'b0;
    wait (waiting == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bcts_pkg.sv
hw/rtl/bcts_core.sv
hw/rtl/byte_command_time_switch_unit.sv
verif/bcts_result_monitor.sv
verif/tb_top.sv
